@@ rtl/psob_pkg.sv @@
// Shared types and channel arithmetic for the source-over blend pipeline.
// No dependencies; imported by every module of the block.
package psob_pkg;

   localparam int unsigned PixelWidth = 32;
   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned NumChans   = PixelWidth / ChanWidth;
   localparam int unsigned ProdWidth  = 2 * ChanWidth;

   localparam logic [ChanWidth-1:0]  ChanFull   = 8'hff;
   localparam logic [ProdWidth:0]    RoundHalf  = 17'h00080;
   localparam logic [PixelWidth-1:0] ChanMask   = 32'h00ff00ff;

   typedef logic [PixelWidth-1:0] pixel_type;
   typedef logic [ChanWidth-1:0]  chan_type;
   typedef logic [ProdWidth-1:0]  prod_type;

   // Beat passed from the source scaling half to the blending half.
   typedef struct packed {
      pixel_type src;       // source, scaled by the constant alpha where needed
      pixel_type dst;
      chan_type  inv_alpha; // 255 minus the (scaled) source alpha
      logic      zero_src;
      logic      pass_src;
      logic      span_end;
   } psob_item_type;

   // Divide-by-255 approximation: (t + (t >> 8) + 128) >> 8.
   function automatic chan_type chan_round(input prod_type t);
      logic [ProdWidth:0] sum;
      sum = {1'b0, t} + {9'd0, t[ProdWidth-1:ChanWidth]} + RoundHalf;
      return sum[ProdWidth-1:ChanWidth];
   endfunction

   // Per-byte add, wrapping in each channel.
   function automatic pixel_type byte_add(input pixel_type x, input pixel_type y);
      pixel_type lo;
      pixel_type hi;
      lo = (x & ChanMask) + (y & ChanMask);
      hi = ((x >> ChanWidth) & ChanMask) + ((y >> ChanWidth) & ChanMask);
      return (lo & ChanMask) | ((hi & ChanMask) << ChanWidth);
   endfunction

endpackage

@@ rtl/premultiplied_source_over_blend_unit.sv @@
// Source-over compositing of premultiplied ARGB32 pixels with a global opacity.
// Top level; depends on psob_pkg, psob_src_scale and psob_dst_blend.
//
// Each request beat carries one premultiplied source pixel, the destination
// pixel and a span marker; each response beat carries the composited pixel,
// a flag that is set when the source was all zero (destination kept as is)
// and the span marker. The block takes one beat per clock while the response
// side accepts beats, and presents the result on the response port through
// four register stages (the first captures the request): source times
// constant alpha, rounding and inverse alpha, destination times inverse
// alpha, and rounding with the per-byte wrapping add into the output
// register. Every stage carries its own valid bit, so back-pressure on the
// response side stalls the pipe without dropping or repeating a beat, and
// bubbles are squeezed out as they reach a stall. The constant alpha (reset
// value 255, fully opaque) is written through the csr port, which is always
// ready; write it only while no beat is in flight.
module premultiplied_source_over_blend_unit import psob_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   // request channel
   input  logic      req_valid,
   output logic      req_ready,
   input  pixel_type req_source_pixel,
   input  pixel_type req_dest_pixel,
   input  logic      req_span_end,
   // response channel
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output pixel_type rsp_blended_pixel,
   output logic      rsp_dest_untouched,
   output logic      rsp_span_end_out,
   // configuration: constant alpha
   input  logic      csr_valid,
   output logic      csr_ready,
   input  chan_type  csr_data
);

   chan_type      global_alpha_ff;
   logic          mid_valid;
   logic          mid_ready;
   psob_item_type mid_item;

   // Hold the global opacity; take every write at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         global_alpha_ff <= ChanFull;
      end else if (csr_valid && csr_ready) begin
         global_alpha_ff <= csr_data;
      end
   end

   // Scale the source and work out the weight left for the destination.
   psob_src_scale u_src_scale (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .up_src       (req_source_pixel),
      .up_dst       (req_dest_pixel),
      .up_span_end  (req_span_end),
      .global_alpha (global_alpha_ff),
      .down_valid   (mid_valid),
      .down_ready   (mid_ready),
      .down_item    (mid_item)
   );

   // Weight the destination, add the source and register the result.
   psob_dst_blend u_dst_blend (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (mid_valid),
      .up_ready      (mid_ready),
      .up_item       (mid_item),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_pixel     (rsp_blended_pixel),
      .out_untouched (rsp_dest_untouched),
      .out_span_end  (rsp_span_end_out)
   );

endmodule

@@ rtl/psob_src_scale.sv @@
// Two pipeline stages: multiply the source channels by the constant alpha,
// then round and derive the inverse source alpha. Depends on psob_pkg.
module psob_src_scale import psob_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  pixel_type     up_src,
   input  pixel_type     up_dst,
   input  logic          up_span_end,
   input  chan_type      global_alpha,
   output logic          down_valid,
   input  logic          down_ready,
   output psob_item_type down_item
);

   // stage A
   logic      a_valid_ff;
   pixel_type a_src_ff;
   pixel_type a_dst_ff;
   prod_type  a_prod_ff [NumChans];
   logic      a_full_ff;
   logic      a_zero_ff;
   logic      a_pass_ff;
   logic      a_end_ff;
   // stage B
   logic          b_valid_ff;
   psob_item_type b_item_ff;
   psob_item_type b_item_in;

   logic a_en;
   logic b_en;

   assign b_en     = !b_valid_ff || down_ready;
   assign a_en     = !a_valid_ff || b_en;
   assign up_ready = a_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= up_valid;
      end
      if (a_en && up_valid) begin
         for (int i = 0; i < NumChans; i++) begin
            a_prod_ff[i] <= prod_type'(up_src[i*ChanWidth +: ChanWidth]) *
                            prod_type'(global_alpha);
         end
         a_src_ff  <= up_src;
         a_dst_ff  <= up_dst;
         a_full_ff <= (global_alpha == ChanFull);
         a_zero_ff <= (up_src == '0);
         a_pass_ff <= (global_alpha == ChanFull) &&
                      (up_src[PixelWidth-1 -: ChanWidth] == ChanFull);
         a_end_ff  <= up_span_end;
      end
   end

   always_comb begin
      pixel_type scaled;
      scaled = '0;
      for (int i = 0; i < NumChans; i++) begin
         scaled[i*ChanWidth +: ChanWidth] = chan_round(a_prod_ff[i]);
      end
      b_item_in.src       = a_full_ff ? a_src_ff : scaled;
      b_item_in.dst       = a_dst_ff;
      b_item_in.inv_alpha = ChanFull - b_item_in.src[PixelWidth-1 -: ChanWidth];
      b_item_in.zero_src  = a_zero_ff;
      b_item_in.pass_src  = a_pass_ff;
      b_item_in.span_end  = a_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_en && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   assign down_valid = b_valid_ff;
   assign down_item  = b_item_ff;

endmodule

@@ rtl/psob_dst_blend.sv @@
// Two pipeline stages: multiply the destination by the inverse source alpha,
// then round, add the source and pick the result. Depends on psob_pkg.
module psob_dst_blend import psob_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  psob_item_type up_item,
   output logic          out_valid,
   input  logic          out_ready,
   output pixel_type     out_pixel,
   output logic          out_untouched,
   output logic          out_span_end
);

   // stage C
   logic      c_valid_ff;
   pixel_type c_src_ff;
   pixel_type c_dst_ff;
   prod_type  c_prod_ff [NumChans];
   logic      c_zero_ff;
   logic      c_pass_ff;
   logic      c_end_ff;
   // stage D (output register)
   logic      d_valid_ff;
   pixel_type d_pixel_ff;
   pixel_type d_pixel_in;
   logic      d_untouched_ff;
   logic      d_end_ff;

   logic c_en;
   logic d_en;

   assign d_en     = !d_valid_ff || out_ready;
   assign c_en     = !c_valid_ff || d_en;
   assign up_ready = c_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_en) begin
         c_valid_ff <= up_valid;
      end
      if (c_en && up_valid) begin
         for (int i = 0; i < NumChans; i++) begin
            c_prod_ff[i] <= prod_type'(up_item.dst[i*ChanWidth +: ChanWidth]) *
                            prod_type'(up_item.inv_alpha);
         end
         c_src_ff  <= up_item.src;
         c_dst_ff  <= up_item.dst;
         c_zero_ff <= up_item.zero_src;
         c_pass_ff <= up_item.pass_src;
         c_end_ff  <= up_item.span_end;
      end
   end

   always_comb begin
      pixel_type dst_scaled;
      dst_scaled = '0;
      for (int i = 0; i < NumChans; i++) begin
         dst_scaled[i*ChanWidth +: ChanWidth] = chan_round(c_prod_ff[i]);
      end
      if (c_zero_ff) begin
         d_pixel_in = c_dst_ff;
      end else if (c_pass_ff) begin
         d_pixel_in = c_src_ff;
      end else begin
         d_pixel_in = byte_add(c_src_ff, dst_scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_en) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_en && c_valid_ff) begin
         d_pixel_ff     <= d_pixel_in;
         d_untouched_ff <= c_zero_ff;
         d_end_ff       <= c_end_ff;
      end
   end

   assign out_valid     = d_valid_ff;
   assign out_pixel     = d_pixel_ff;
   assign out_untouched = d_untouched_ff;
   assign out_span_end  = d_end_ff;

endmodule

@@ verif/premultiplied_source_over_blend_unit_tb.sv @@
// Self-checking testbench for premultiplied_source_over_blend_unit.
// Depends on psob_pkg for the pixel and channel types and on the block's RTL.
// Runs a directed table and random phases over several constant alpha values.
`timescale 1ns / 1ps

module premultiplied_source_over_blend_unit_tb import psob_pkg::*; ();

   localparam int unsigned CycleLimit     = 400000;
   localparam int unsigned MaxWait        = 17;
   localparam int unsigned PhaseCount     = 8;
   localparam int unsigned ItemsPerPhase  = 168;
   localparam int unsigned DrainCycles    = 8;
   localparam int unsigned DirectedCount  = 23;
   localparam chan_type    OpaqueAlpha    = 8'hff;

   // One composited pixel as the block should return it.
   typedef struct packed {
      pixel_type pixel;
      logic      untouched;
      logic      span_end;
   } blend_result_type;

   // Directed stimulus row. Where 'typed' is set the expected pixel and flag
   // are written in by hand; otherwise the predictor supplies them.
   typedef struct packed {
      chan_type  alpha;
      pixel_type src;
      pixel_type dst;
      logic      span_end;
      logic      typed;
      pixel_type exp_pixel;
      logic      exp_untouched;
   } directed_row_type;

   localparam directed_row_type DirectedRows [DirectedCount] = '{
      // full opacity: zero source keeps the destination
      '{8'hff, 32'h00000000, 32'h12345678, 1'b0, 1'b1, 32'h12345678, 1'b1},
      '{8'hff, 32'h00000000, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff, 1'b1},
      '{8'hff, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 32'h00000000, 1'b1},
      // full opacity: opaque source passes straight through
      '{8'hff, 32'hff000000, 32'hffffffff, 1'b0, 1'b1, 32'hff000000, 1'b0},
      '{8'hff, 32'hffffffff, 32'h00000000, 1'b1, 1'b1, 32'hffffffff, 1'b0},
      '{8'hff, 32'hff123456, 32'ha5a5a5a5, 1'b0, 1'b1, 32'hff123456, 1'b0},
      // transparent alpha with colour, byte wrap, non-premultiplied colour
      '{8'hff, 32'h00000001, 32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{8'hff, 32'h00ffffff, 32'h01010101, 1'b1, 1'b0, 32'h0, 1'b0},
      '{8'hff, 32'h80ffffff, 32'h80808080, 1'b0, 1'b0, 32'h0, 1'b0},
      '{8'hff, 32'h80808080, 32'hffffffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{8'hff, 32'hfe010203, 32'hfffefdfc, 1'b1, 1'b0, 32'h0, 1'b0},
      '{8'hff, 32'h01000000, 32'h55aa55aa, 1'b0, 1'b0, 32'h0, 1'b0},
      // zero opacity: the source scales away, the destination survives
      '{8'h00, 32'h00000000, 32'h89abcdef, 1'b1, 1'b1, 32'h89abcdef, 1'b1},
      '{8'h00, 32'hffffffff, 32'h5a5aa5a5, 1'b0, 1'b1, 32'h5a5aa5a5, 1'b0},
      '{8'h00, 32'h00000001, 32'h00000000, 1'b1, 1'b1, 32'h00000000, 1'b0},
      '{8'h00, 32'hff000000, 32'hffffffff, 1'b0, 1'b1, 32'hffffffff, 1'b0},
      // smallest nonzero opacity
      '{8'h01, 32'hffffffff, 32'hffffffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{8'h01, 32'h00000000, 32'h76543210, 1'b1, 1'b1, 32'h76543210, 1'b1},
      // half opacity
      '{8'h80, 32'hff000000, 32'hffffffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{8'h80, 32'h80404040, 32'h11223344, 1'b1, 1'b0, 32'h0, 1'b0},
      // just below full: opaque source no longer passes through
      '{8'hfe, 32'hff000000, 32'h00ffffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{8'hfe, 32'hffffffff, 32'hffffffff, 1'b1, 1'b0, 32'h0, 1'b0},
      '{8'hfe, 32'h7f7f7f7f, 32'h80808080, 1'b0, 1'b0, 32'h0, 1'b0}
   };

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   pixel_type req_source_pixel;
   pixel_type req_dest_pixel;
   logic      req_span_end;
   logic      rsp_valid;
   logic      rsp_ready;
   pixel_type rsp_blended_pixel;
   logic      rsp_dest_untouched;
   logic      rsp_span_end_out;
   logic      csr_valid;
   logic      csr_ready;
   chan_type  csr_data;

   // Opacity as the predictor sees it; follows accepted csr beats.
   chan_type         blend_alpha;
   // Opacity last requested by the stimulus, to spot when a write is due.
   chan_type         stim_alpha;
   blend_result_type pending_pixels [$];

   // Hand-typed expectation for the beat now on the request channel.
   logic             typed_valid;
   pixel_type        typed_pixel;
   logic             typed_untouched;

   logic             sender_burst;
   logic             receiver_burst;

   int unsigned      cycle_count;
   int unsigned      error_count;
   int unsigned      checked_count;
   int unsigned      zero_src_count;
   int unsigned      opaque_count;
   int unsigned      alpha_writes;

   premultiplied_source_over_blend_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_source_pixel   (req_source_pixel),
      .req_dest_pixel     (req_dest_pixel),
      .req_span_end       (req_span_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blended_pixel  (rsp_blended_pixel),
      .rsp_dest_untouched (rsp_dest_untouched),
      .rsp_span_end_out   (rsp_span_end_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Scale one channel by a factor, dividing by 255 with rounding.
   function automatic chan_type scale_chan(input chan_type c, input chan_type a);
      logic [16:0] acc;
      acc = {9'd0, c} * {9'd0, a};
      acc = acc + (acc >> 8) + 17'd128;
      return acc[15:8];
   endfunction

   function automatic pixel_type scale_argb(input pixel_type p, input chan_type a);
      pixel_type scaled;
      for (int k = 0; k < 4; k++)
         scaled[8*k +: 8] = scale_chan(p[8*k +: 8], a);
      return scaled;
   endfunction

   // Add byte by byte; each channel wraps on its own.
   function automatic pixel_type wrap_add(input pixel_type x, input pixel_type y);
      pixel_type total;
      for (int k = 0; k < 4; k++)
         total[8*k +: 8] = x[8*k +: 8] + y[8*k +: 8];
      return total;
   endfunction

   function automatic blend_result_type predict_blend(input pixel_type src,
                                                      input pixel_type dst,
                                                      input logic      span_end,
                                                      input chan_type  alpha);
      blend_result_type result;
      pixel_type        scaled;
      chan_type         inv_alpha;
      result.span_end  = span_end;
      result.untouched = 1'b0;
      if (src == '0) begin
         result.pixel     = dst;
         result.untouched = 1'b1;
      end else if (alpha == OpaqueAlpha && src[31:24] == OpaqueAlpha) begin
         result.pixel = src;
      end else begin
         scaled          = (alpha == OpaqueAlpha) ? src : scale_argb(src, alpha);
         inv_alpha       = OpaqueAlpha - scaled[31:24];
         result.pixel    = wrap_add(scaled, scale_argb(dst, inv_alpha));
      end
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Random pixel sources
   // ---------------------------------------------------------------------

   // Mostly well-formed premultiplied pixels, with zero, opaque, transparent
   // and fully random (non-premultiplied) ones mixed in.
   function automatic pixel_type random_source();
      int unsigned kind;
      int unsigned a;
      pixel_type   p;
      kind = $urandom_range(0, 99);
      p    = $urandom();
      if (kind < 10) begin
         p = '0;
      end else if (kind < 25) begin
         p[31:24] = OpaqueAlpha;
      end else if (kind < 35) begin
         p[31:24] = 8'h00;
         if (p == '0)
            p[0] = 1'b1;
      end else if (kind >= 45) begin
         a        = $urandom_range(1, 254);
         p[31:24] = a[7:0];
         for (int k = 0; k < 3; k++)
            p[8*k +: 8] = 8'($urandom_range(0, a));
      end
      return p;
   endfunction

   function automatic pixel_type random_dest();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind == 0)
         return '0;
      if (kind == 1)
         return '1;
      return $urandom();
   endfunction

   // Idle cycles before the next beat: none during a burst, else 0..MaxWait.
   function automatic int unsigned draw_wait(input logic burst);
      return burst ? 0 : $urandom_range(0, MaxWait);
   endfunction

   // ---------------------------------------------------------------------
   // Request and configuration drivers (called at a falling edge; each
   // returns at the falling edge after its beat has been taken)
   // ---------------------------------------------------------------------

   task automatic send_pixel(input pixel_type src, input pixel_type dst,
                             input logic span_end, input logic typed,
                             input pixel_type exp_pixel, input logic exp_untouched);
      int unsigned idle;
      if ($urandom_range(0, 39) == 0)
         sender_burst = ~sender_burst;
      idle = draw_wait(sender_burst);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      typed_valid      = typed;
      typed_pixel      = exp_pixel;
      typed_untouched  = exp_untouched;
      req_valid        <= 1'b1;
      req_source_pixel <= src;
      req_dest_pixel   <= dst;
      req_span_end     <= span_end;
      // hold the beat until it is taken
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Wait until every beat in flight has come back.
   task automatic drain_pipe();
      while (pending_pixels.size() != 0)
         @(negedge clock);
   endtask

   // Drop the request, let the pipe empty, then write the constant alpha.
   task automatic write_alpha(input chan_type alpha);
      req_valid <= 1'b0;
      drain_pipe();
      csr_valid <= 1'b1;
      csr_data  <= alpha;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid  <= 1'b0;
      stim_alpha = alpha;
      alpha_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: queue an expectation on every accepted request beat, check every accepted
   // response beat against the oldest expectation

   always @(posedge clock) begin
      blend_result_type want;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d beats outstanding",
                  $time, cycle_count, pending_pixels.size());
         $display("== FAIL ==");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready)
            blend_alpha <= csr_data;
         if (req_valid && req_ready) begin
            if (typed_valid)
               pending_pixels.push_back('{typed_pixel, typed_untouched, req_span_end});
            else
               pending_pixels.push_back(predict_blend(req_source_pixel, req_dest_pixel,
                                                      req_span_end, blend_alpha));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected response beat, pixel %h", $time,
                        rsp_blended_pixel);
               error_count++;
            end else begin
               want = pending_pixels.pop_front();
               checked_count++;
               if (want.untouched)
                  zero_src_count++;
               if (rsp_blended_pixel !== want.pixel) begin
                  $display("%0t: blended_pixel expected %h, got %h", $time,
                           want.pixel, rsp_blended_pixel);
                  error_count++;
               end
               if (rsp_dest_untouched !== want.untouched) begin
                  $display("%0t: dest_untouched expected %b, got %b", $time,
                           want.untouched, rsp_dest_untouched);
                  error_count++;
               end
               if (rsp_span_end_out !== want.span_end) begin
                  $display("%0t: span_end_out expected %b, got %b", $time,
                           want.span_end, rsp_span_end_out);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: stall a random number of cycles before each beat
   // ---------------------------------------------------------------------

   initial begin
      int unsigned stall;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 39) == 0)
            receiver_burst = ~receiver_burst;
         stall = draw_wait(receiver_burst);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      directed_row_type row;
      pixel_type        src;
      chan_type         phase_alpha [PhaseCount];

      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_source_pixel = '0;
      req_dest_pixel   = '0;
      req_span_end     = 1'b0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      blend_alpha      = OpaqueAlpha;
      stim_alpha       = OpaqueAlpha;
      typed_valid      = 1'b0;
      typed_pixel      = '0;
      typed_untouched  = 1'b0;
      sender_burst     = 1'b0;
      receiver_burst   = 1'b0;
      cycle_count      = 0;
      error_count      = 0;
      checked_count    = 0;
      zero_src_count   = 0;
      opaque_count     = 0;
      alpha_writes     = 0;

      // hold reset, then release it at a falling edge
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table: reprogram the opacity whenever a row asks for a
      // different one, then send the row; rows go in order, with random idle gaps.
      for (int r = 0; r < DirectedCount; r++) begin
         row = DirectedRows[r];
         if (row.alpha != stim_alpha)
            write_alpha(row.alpha);
         send_pixel(row.src, row.dst, row.span_end, row.typed,
                    row.exp_pixel, row.exp_untouched);
      end

      // Random phases: 0, 255, 1, 254, half opacity, two arbitrary values and full opacity again.
      phase_alpha = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h00, 8'h00, 8'hff};
      phase_alpha[5] = 8'($urandom_range(2, 253));
      phase_alpha[6] = 8'($urandom_range(2, 253));
      for (int ph = 0; ph < PhaseCount; ph++) begin
         write_alpha(phase_alpha[ph]);
         for (int n = 0; n < ItemsPerPhase; n++) begin
            src = random_source();
            if (src[31:24] == OpaqueAlpha)
               opaque_count++;
            send_pixel(src, random_dest(), $urandom_range(0, 7) == 0,
                       1'b0, '0, 1'b0);
         end
      end

      // drop valid, let the pipe empty, then idle for DrainCycles to catch any stray response beat
      req_valid <= 1'b0;
      drain_pipe();
      repeat (DrainCycles) @(negedge clock);

      $display("Checked %0d blended pixels over %0d opacity writes.",
               checked_count, alpha_writes);
      $display("Zero sources: %0d, random opaque sources: %0d, mismatches: %0d.",
               zero_src_count, opaque_count, error_count);
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/psob_pkg.sv
rtl/psob_src_scale.sv
rtl/psob_dst_blend.sv
rtl/premultiplied_source_over_blend_unit.sv
verif/premultiplied_source_over_blend_unit_tb.sv
